// File: rtl/core/tsa_pkg.sv
// ============================================================================
// tsa_pkg: shared constants, types and helpers for the solid angle engine
// Holds the widths of the fixed-point datapath, the CORDIC arctangent table
// and the struct that carries one classified item from front to back.
// ============================================================================
package tsa_pkg;

    localparam int COORD_WIDTH_DEF     = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int CORDIC_STEPS_DEF    = 20;

    // Magnitudes handed to the CORDIC are at most this many bits.
    localparam int CordicLimit = 60;
    // Working width of the CORDIC x and y registers (sign and growth room).
    localparam int CW = 64;
    localparam int ZW = 34;

    localparam logic [ZW-1:0] PI_Q30      = 34'd3373259426;
    localparam logic [ZW-1:0] HALF_PI_Q30 = 34'd1686629713;

    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] r;
        begin
            case (i)
                0: r = 32'h3243F6A8;  1: r = 32'h1DAC6705;  2: r = 32'h0FADBAFC;
                3: r = 32'h07F56EA6;  4: r = 32'h03FEAB76;  5: r = 32'h01FFD55B;
                6: r = 32'h00FFFAAA;  7: r = 32'h007FFF55;  8: r = 32'h003FFFEA;
                9: r = 32'h001FFFFD; 10: r = 32'h000FFFFF; 11: r = 32'h0007FFFF;
                12: r = 32'h0003FFFF; 13: r = 32'h0001FFFF; 14: r = 32'h0000FFFF;
                15: r = 32'h00007FFF; 16: r = 32'h00003FFF; 17: r = 32'h00001FFF;
                18: r = 32'h00000FFF; 19: r = 32'h000007FF; 20: r = 32'h000003FF;
                21: r = 32'h000001FF; 22: r = 32'h000000FF; 23: r = 32'h0000007F;
                24: r = 32'h0000003F; 25: r = 32'h0000001F; 26: r = 32'h0000000F;
                27: r = 32'h00000008; 28: r = 32'h00000004; 29: r = 32'h00000002;
                30: r = 32'h00000001;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

    // One classified item: CORDIC start vector and its special-case flags.
    typedef struct packed {
        logic          zero_det;
        logic          degen;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [ZW-1:0] z;
    } tsa_item_t;

endpackage

// File: rtl/core/tsa_front.sv
// ============================================================================
// tsa_front: geometry front end
// Pipelined products, norms (one root bit per stage), determinant and
// divisor, then range scaling and quadrant fold into a CORDIC start vector.
// All stages advance together, only when the last stage is empty or its item is taken.
// ============================================================================
module tsa_front
    import tsa_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] ax, ay, az, bx, by, bz, cx, cy, cz,
    output logic                          item_valid,
    input  logic                          item_ready,
    output tsa_item_t                     item
);
    localparam int PW  = 2 * COORD_WIDTH + 2;          // pair products and dots
    localparam int SQW = 2 * COORD_WIDTH + 2 + 16;     // squared norm << 16
    localparam int RW  = SQW / 2 + 1;                  // root width
    localparam int RSTEPS = (SQW + 1) / 2;
    localparam int DW  = 3 * COORD_WIDTH + 4;          // det width
    localparam int WW  = 128;                          // wide divisor/det words
    localparam int NS  = 4 + RSTEPS + 4;               // total stages
    localparam int SIW = $clog2(WW + 1);

    // Per-stage valid bits with a simple stall: all stages share one enable.
    logic [NS-1:0] vld_reg;
    logic          adv;
    assign adv      = !vld_reg[NS-1] || item_ready;
    assign in_ready = adv;
    assign item_valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NS-2:0], in_valid};
    end

    // Stage 1: coordinate products.
    logic signed [COORD_WIDTH-1:0] a1_reg [3], b1_reg [3], c1_reg [3];
    logic signed [PW-1:0] k1_reg, k2_reg, k3_reg;
    logic signed [PW-1:0] aa_reg, bb_reg, cc_reg, ab_reg, ac_reg, bc_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg <= '{ax, ay, az};
            b1_reg <= '{bx, by, bz};
            c1_reg <= '{cx, cy, cz};
            k1_reg <= PW'(by * cz) - PW'(cy * bz);
            k2_reg <= PW'(ay * cz) - PW'(cy * az);
            k3_reg <= PW'(ay * bz) - PW'(by * az);
            aa_reg <= PW'(ax * ax) + PW'(ay * ay) + PW'(az * az);
            bb_reg <= PW'(bx * bx) + PW'(by * by) + PW'(bz * bz);
            cc_reg <= PW'(cx * cx) + PW'(cy * cy) + PW'(cz * cz);
            ab_reg <= PW'(ax * bx) + PW'(ay * by) + PW'(az * bz);
            ac_reg <= PW'(ax * cx) + PW'(ay * cy) + PW'(az * cz);
            bc_reg <= PW'(bx * cx) + PW'(by * cy) + PW'(bz * cz);
        end
    end

    // Stage 2: determinant partial products.
    logic signed [DW-1:0] d1_reg, d2_reg, d3_reg;
    logic signed [PW-1:0] ab2_reg, ac2_reg, bc2_reg;
    logic [SQW-1:0] sq_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d1_reg  <= DW'(a1_reg[0] * k1_reg);
            d2_reg  <= DW'(b1_reg[0] * k2_reg);
            d3_reg  <= DW'(c1_reg[0] * k3_reg);
            ab2_reg <= ab_reg;
            ac2_reg <= ac_reg;
            bc2_reg <= bc_reg;
            sq_reg[0] <= SQW'(unsigned'(aa_reg)) << 16;
            sq_reg[1] <= SQW'(unsigned'(bb_reg)) << 16;
            sq_reg[2] <= SQW'(unsigned'(cc_reg)) << 16;
        end
    end

    // Stage 3 loads; stages 4 .. 3+RSTEPS: restoring square root, one result bit per stage.
    logic [SQW-1:0] rem_reg  [RSTEPS+1][3];
    logic [RW-1:0]  root_reg [RSTEPS+1][3];
    logic signed [DW-1:0] det_pipe_reg [RSTEPS+1];
    logic signed [PW-1:0] abp_reg [RSTEPS+1], acp_reg [RSTEPS+1], bcp_reg [RSTEPS+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int v = 0; v < 3; v++)
            begin
                rem_reg[0][v]  <= sq_reg[v];
                root_reg[0][v] <= '0;
            end
            det_pipe_reg[0] <= d1_reg - d2_reg + d3_reg;
            abp_reg[0] <= ab2_reg;
            acp_reg[0] <= ac2_reg;
            bcp_reg[0] <= bc2_reg;
        end
    end

    for (genvar s = 0; s < RSTEPS; s++)
    begin : g_root
        localparam int SH = 2 * (RSTEPS - 1 - s);
        for (genvar v = 0; v < 3; v++)
        begin : g_vec
            logic [SQW+1:0] trial;
            logic [SQW+1:0] cand;
            assign cand  = ((SQW+2)'({root_reg[s][v], 2'b01})) << SH;
            assign trial = (SQW+2)'(rem_reg[s][v]);
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (trial >= cand)
                    begin
                        rem_reg[s+1][v]  <= SQW'(trial - cand);
                        root_reg[s+1][v] <= {root_reg[s][v][RW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[s+1][v]  <= rem_reg[s][v];
                        root_reg[s+1][v] <= {root_reg[s][v][RW-2:0], 1'b0};
                    end
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                det_pipe_reg[s+1] <= det_pipe_reg[s];
                abp_reg[s+1] <= abp_reg[s];
                acp_reg[s+1] <= acp_reg[s];
                bcp_reg[s+1] <= bcp_reg[s];
            end
        end
    end

    logic [RW-1:0] na, nb, nc;
    assign na = root_reg[RSTEPS][0];
    assign nb = root_reg[RSTEPS][1];
    assign nc = root_reg[RSTEPS][2];

    // Divisor stage A: product of two norms and the dot-times-norm terms.
    logic [2*RW-1:0]      nab_reg;
    logic [RW-1:0]        nc_reg;
    logic signed [WW-1:0] t1_reg, t2_reg, t3_reg, detA_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nab_reg  <= na * nb;
            nc_reg   <= nc;
            t1_reg   <= WW'(abp_reg[RSTEPS] * $signed({1'b0, nc}));
            t2_reg   <= WW'(acp_reg[RSTEPS] * $signed({1'b0, nb}));
            t3_reg   <= WW'(bcp_reg[RSTEPS] * $signed({1'b0, na}));
            detA_reg <= WW'(det_pipe_reg[RSTEPS]);
        end
    end

    // Divisor stage B: the triple norm product is split into two halves so
    // that each multiplier stays narrow.
    logic [2*RW-1:0]      pl_reg, ph_reg;
    logic signed [WW-1:0] ts_reg, detP_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pl_reg   <= nab_reg[RW-1:0] * nc_reg;
            ph_reg   <= nab_reg[2*RW-1:RW] * nc_reg;
            ts_reg   <= t1_reg + t2_reg + t3_reg;
            detP_reg <= detA_reg;
        end
    end

    // Divisor stage B2: sum.
    logic signed [WW-1:0] div_reg, detB_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_reg  <= WW'(pl_reg) + (WW'(ph_reg) << RW) + (ts_reg <<< 16);
            detB_reg <= detP_reg;
        end
    end

    // Stage C: magnitudes and common bit length.
    logic [WW-1:0] ym_reg, xm_reg;
    logic          xneg_reg, zdet_reg, zdiv_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ym_reg   <= (detB_reg[WW-1] ? WW'(-detB_reg) : WW'(detB_reg)) << 24;
            xm_reg   <= div_reg[WW-1] ? WW'(-div_reg) : WW'(div_reg);
            xneg_reg <= div_reg[WW-1];
            zdet_reg <= (detB_reg == '0);
            zdiv_reg <= (div_reg == '0);
        end
    end

    logic [SIW-1:0] len;
    always_comb
    begin
        len = '0;
        for (int i = 0; i < WW; i++)
            if (ym_reg[i] || xm_reg[i])
                len = SIW'(i + 1);
    end

    // Stage D: scale and fold the left half plane.
    logic [SIW-1:0] sh;
    logic signed [CW-1:0] xs, ys;
    assign sh = (len > SIW'(CordicLimit)) ? len - SIW'(CordicLimit) : '0;
    assign ys = CW'(ym_reg >> sh);
    assign xs = xneg_reg ? -CW'(xm_reg >> sh) : CW'(xm_reg >> sh);

    tsa_item_t out_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.zero_det <= zdet_reg;
            out_reg.degen    <= zdet_reg && zdiv_reg;
            if (xs < 0)
            begin
                out_reg.x <= ys;
                out_reg.y <= -xs;
                out_reg.z <= HALF_PI_Q30;
            end
            else
            begin
                out_reg.x <= xs;
                out_reg.y <= ys;
                out_reg.z <= '0;
            end
        end
    end
    assign item = out_reg;

endmodule

// File: rtl/core/tsa_fifo.sv
// ============================================================================
// tsa_fifo: short decoupling queue
// Four-entry queue between the geometry front end and the CORDIC back end.
// ============================================================================
module tsa_fifo
    import tsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  tsa_item_t wr_data,
    output logic      rd_valid,
    input  logic      rd_ready,
    output tsa_item_t rd_data
);
    tsa_item_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = (cnt_reg != 3'd4);
    assign rd_valid = (cnt_reg != 3'd0);
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= wp_reg + 2'd1;
            if (rd) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(wr) - 3'(rd);
        end
    end

endmodule

// File: rtl/core/tsa_cordic.sv
// ============================================================================
// tsa_cordic: vectoring CORDIC back end
// One rotation per pipeline stage, then clamp and rounding to the output.
// ============================================================================
module tsa_cordic
    import tsa_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  tsa_item_t                  item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ANGLE_FRAC_BITS+2:0] omega,
    output logic                       degenerate
);
    localparam int NS = CORDIC_STEPS + 1;
    localparam int OW = ANGLE_FRAC_BITS + 3;

    logic [NS-1:0] vld_reg;
    logic adv;
    assign adv        = !vld_reg[NS-1] || out_ready;
    assign item_ready = adv;
    assign out_valid  = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NS-2:0], item_valid};
    end

    logic signed [CW-1:0] x_reg [CORDIC_STEPS+1], y_reg [CORDIC_STEPS+1];
    logic signed [ZW-1:0] z_reg [CORDIC_STEPS+1];
    logic zd_reg [CORDIC_STEPS+1], dg_reg [CORDIC_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0]  <= item.x;
            y_reg[0]  <= item.y;
            z_reg[0]  <= item.z;
            zd_reg[0] <= item.zero_det;
            dg_reg[0] <= item.degen;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        localparam logic signed [ZW-1:0] ANG = ZW'(atan_q30(i));
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ANG;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ANG;
                end
                zd_reg[i+1] <= zd_reg[i];
                dg_reg[i+1] <= dg_reg[i];
            end
        end
    end

    // Clamp to [0, pi] and round to the output scale.
    logic signed [ZW-1:0] zf;
    logic [ZW-1:0] zc, zr;
    assign zf = z_reg[CORDIC_STEPS];
    assign zc = (zf < 0) ? '0 : ((zf > $signed(PI_Q30)) ? PI_Q30 : zf);
    assign zr = (zc + (ZW'(1) << (28 - ANGLE_FRAC_BITS))) >> (29 - ANGLE_FRAC_BITS);
    assign omega      = zd_reg[CORDIC_STEPS] ? '0 : OW'(zr);
    assign degenerate = dg_reg[CORDIC_STEPS];

endmodule

// File: rtl/core/triangle_solid_angle.sv
// ============================================================================
// triangle_solid_angle: solid angle of an apex triangle
// Pipelined geometry front end, a short queue, and a pipelined CORDIC.
// ============================================================================
//   channel  | handshake          | payload
//   input    | in_valid/in_ready  | ax ay az bx by bz cx cy cz
//   output   | out_valid/out_ready| omega degenerate
//
// One transfer per cycle is sustained while the output is not stalled. An
// input transfer passes the front stages (dominated by the one-bit-per-stage
// square root), the queue memory and 21 CORDIC stages before it is output.
// Reset clears only the valid bits and the queue pointers and count.
// Either side may stall; the queue lets the halves stall independently.
module triangle_solid_angle
    import tsa_pkg::*;
#(
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] ax, ay, az, bx, by, bz, cx, cy, cz,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ANGLE_FRAC_BITS+2:0]    omega,
    output logic                          degenerate
);
    tsa_item_t f_item, q_item;
    logic f_valid, f_ready, q_valid, q_ready;

    tsa_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk, .rst_n, .in_valid, .in_ready,
        .ax, .ay, .az, .bx, .by, .bz, .cx, .cy, .cz,
        .item_valid(f_valid), .item_ready(f_ready), .item(f_item)
    );

    tsa_fifo u_fifo (
        .clk, .rst_n,
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_item),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_item)
    );

    tsa_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk, .rst_n,
        .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
        .out_valid, .out_ready, .omega, .degenerate
    );

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> omega == '0)
        else $error("degenerate result with nonzero angle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(omega))
        else $error("result changed while stalled");

endmodule

// File: test/tsa_checker.sv
// ============================================================================
// tsa_checker: result predictor and comparator for triangle_solid_angle
// Watches both channels. Each input transfer is turned into an expected solid
// angle and degenerate flag. Each output transfer is compared against the
// oldest expectation.
// ============================================================================
module tsa_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [18:0]        omega,
    input  logic               degenerate,
    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        logic [18:0] omega;
        logic        degen;
    } angle_t;

    localparam longint PI_Q30      = 64'd3373259426;
    localparam longint HALF_PI_Q30 = 64'd1686629713;

    localparam logic [31:0] ATAN_Q30 [20] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF
    };

    angle_t angle_q[$];

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int bit_len(input logic [127:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 128; i++)
            if (v[i])
                n = i + 1;
        return n;
    endfunction

    function automatic angle_t predict_angle(input longint a[3], input longint b[3],
                                             input longint c[3]);
        angle_t res;
        longint k1, k2, k3, x, y, z, t, dx, dy;
        logic signed [127:0] det, dv, ym, xm, p0, p1, p2, wa, wb, wc;
        longint unsigned na, nb, nc;
        int len, s;
        logic xneg;
        res = '0;
        k1 = b[1] * c[2] - c[1] * b[2];
        k2 = a[1] * c[2] - c[1] * a[2];
        k3 = a[1] * b[2] - b[1] * a[2];
        p0 = a[0];
        p1 = k1;
        det = p0 * p1;
        p0 = b[0];
        p1 = k2;
        det = det - p0 * p1;
        p0 = c[0];
        p1 = k3;
        det = det + p0 * p1;

        na = int_sqrt(longint'(a[0]*a[0] + a[1]*a[1] + a[2]*a[2]) << 16);
        nb = int_sqrt(longint'(b[0]*b[0] + b[1]*b[1] + b[2]*b[2]) << 16);
        nc = int_sqrt(longint'(c[0]*c[0] + c[1]*c[1] + c[2]*c[2]) << 16);
        wa = na;
        wb = nb;
        wc = nc;
        dv = wa * wb * wc;
        p0 = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
        dv = dv + ((p0 * wc) <<< 16);
        p1 = a[0]*c[0] + a[1]*c[1] + a[2]*c[2];
        dv = dv + ((p1 * wb) <<< 16);
        p2 = b[0]*c[0] + b[1]*c[1] + b[2]*c[2];
        dv = dv + ((p2 * wa) <<< 16);

        if (det == 0)
        begin
            res.degen = (dv == 0);
            return res;
        end

        ym = (det < 0 ? -det : det) <<< 24;
        xneg = dv < 0;
        xm = xneg ? -dv : dv;
        len = bit_len(ym);
        if (bit_len(xm) > len)
            len = bit_len(xm);
        s = len > 60 ? len - 60 : 0;
        y = longint'(ym >> s);
        x = longint'(xm >> s);
        if (xneg)
            x = -x;

        z = 0;
        // A vector in the left half plane is first turned a quarter turn.
        if (x < 0)
        begin
            t = x;
            x = y;
            y = -t;
            z = HALF_PI_Q30;
        end
        for (int i = 0; i < 20; i++)
        begin
            dx = x >>> i;
            dy = y >>> i;
            if (y > 0)
            begin
                x = x + dy;
                y = y - dx;
                z = z + longint'(ATAN_Q30[i]);
            end
            else
            begin
                x = x - dy;
                y = y + dx;
                z = z - longint'(ATAN_Q30[i]);
            end
        end
        if (z < 0)
            z = 0;
        if (z > PI_Q30)
            z = PI_Q30;
        res.omega = 19'((z + 4096) >>> 13);
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        angle_t want;
        longint a[3], b[3], c[3];
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                a = '{ax, ay, az};
                b = '{bx, by, bz};
                c = '{cx, cy, cz};
                angle_q.push_back(predict_angle(a, b, c));
            end
            if (out_valid && out_ready)
            begin
                if (angle_q.size() == 0)
                    report_mismatch("output transfer with nothing expected");
                else
                begin
                    want = angle_q.pop_front();
                    if (omega !== want.omega)
                        report_mismatch($sformatf("omega %0d, expected %0d",
                                                  omega, want.omega));
                    if (degenerate !== want.degen)
                        report_mismatch($sformatf("degenerate %0b, expected %0b",
                                                  degenerate, want.degen));
                end
            end
            pending = angle_q.size();
        end
    end

endmodule

// File: test/tb_top.sv
// ============================================================================
// tb_top: testbench for triangle_solid_angle
// Drives directed and random vector triples in bursts, stalls the output at
// random, and leaves prediction and comparison to tsa_checker.
// ============================================================================
module tb_top;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    logic              out_valid;
    logic              out_ready;
    logic [18:0]       omega;
    logic              degenerate;
    int                errors;
    int                pending;
    int                stall_mode;

    triangle_solid_angle dut (.*);

    tsa_checker checker_i (.*);

    initial
        clk = 0;
    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // Each transfer: present the triple at a falling edge, hold until taken.
    task automatic send_triple(input logic signed [15:0] v[9]);
        {ax, ay, az, bx, by, bz, cx, cy, cz} = {v[0], v[1], v[2], v[3], v[4],
                                                 v[5], v[6], v[7], v[8]};
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] pick_coord(input int kind);
        logic signed [15:0] ends [6] = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1,
                                         16'sd32767, -16'sd32767};
        case (kind)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(8)) - 4);
            default: return ends[$urandom_range(5)];
        endcase
    endfunction

    task automatic send_random();
        logic signed [15:0] v[9];
        int kind, r;
        r = $urandom_range(99);
        kind = r < 40 ? 0 : (r < 70 ? 1 : 2);
        for (int i = 0; i < 9; i++)
            v[i] = pick_coord(kind);
        // Coplanar triples force a zero determinant.
        if (r >= 85)
            for (int i = 0; i < 3; i++)
            begin
                v[i] = v[i] >>> 1;
                v[3+i] = v[3+i] >>> 1;
                v[6+i] = v[i] + v[3+i];
            end
        send_triple(v);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n || ($urandom_range(199) == 0))
            stall_mode <= $urandom_range(3);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(3) != 0);
            2: out_ready <= ($urandom_range(3) == 0);
            default: out_ready <= 1'($urandom_range(1));
        endcase
    end

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic signed [15:0] v[9];
        int sent, burst, gap;
        rst_n = 0;
        in_valid = 0;
        out_ready = 0;
        stall_mode = 0;
        {ax, ay, az, bx, by, bz, cx, cy, cz} = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Degenerate: all vectors zero.
        v = '{default: 16'sd0};
        send_triple(v);
        // Unit axes, both orientations.
        v = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_triple(v);
        v = '{0, 1, 0, 1, 0, 0, 0, 0, 1};
        send_triple(v);
        // Zero determinant, nonzero divisor: collinear vectors.
        v = '{3, 4, 5, 6, 8, 10, -3, -4, -5};
        send_triple(v);
        // Negative divisor: wide triangle, angle beyond a quarter turn.
        v = '{1, 0, 0, -1, 1, 0, -1, -1, 1};
        send_triple(v);
        v = '{1, 0, 1, -1, 1, 1, -1, -1, 1};
        send_triple(v);
        v = '{100, 0, 1, -50, 87, 1, -50, -87, 1};
        send_triple(v);
        // Extremes of every coordinate.
        v = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};
        send_triple(v);
        v = '{32767, 0, 0, 0, 32767, 0, 0, 0, 32767};
        send_triple(v);
        v = '{-32768, -32768, -32768, 32767, -32768, 32767, 32767, 32767, -32768};
        send_triple(v);
        v = '{-32768, 32767, 0, 32767, -32768, 0, 0, 0, -1};
        send_triple(v);
        v = '{default: -16'sd1};
        send_triple(v);
        v = '{default: 16'sd32767};
        send_triple(v);
        v = '{1, 0, 0, 0, 1, 0, 32767, 32767, 1};
        send_triple(v);

        sent = 0;
        while (sent < 1550)
        begin
            burst = $urandom_range(40, 1);
            for (int i = 0; i < burst; i++)
                send_random();
            sent += burst;
            gap = ($urandom_range(3) != 0) ? int'($urandom_range(12)) : 0;
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/tsa_pkg.sv
rtl/core/tsa_front.sv
rtl/core/tsa_fifo.sv
rtl/core/tsa_cordic.sv
rtl/core/triangle_solid_angle.sv
test/tsa_checker.sv
test/tb_top.sv
